// ----- hdl/utf8v_pkg.sv -----
// Shared types and constants for the UTF-8 stream validator.
// Used by utf8v_step and utf8_stream_validator; no dependencies.
package utf8v_pkg;

    // Field widths
    localparam int unsigned DataW    = 8;
    localparam int unsigned PendW    = 2;
    localparam int unsigned AccumW   = 21;
    localparam int unsigned SeqLenW  = 2;

    // Single-byte limits
    localparam logic [DataW-1:0] CtrlLimit = 8'h20;
    localparam logic [DataW-1:0] DelChar   = 8'h7f;

    // Sequence lengths, counted in continuation bytes
    localparam logic [SeqLenW-1:0] SeqTwoByte   = 2'd1;
    localparam logic [SeqLenW-1:0] SeqThreeByte = 2'd2;
    localparam logic [SeqLenW-1:0] SeqFourByte  = 2'd3;

    // Code point limits
    localparam logic [AccumW-1:0] MinTwoByte   = 21'h00080;
    localparam logic [AccumW-1:0] MinThreeByte = 21'h00800;
    localparam logic [AccumW-1:0] MinFourByte  = 21'h10000;
    localparam logic [AccumW-1:0] MaxCodePoint = 21'h10ffff;
    localparam logic [AccumW-1:0] SurrLow      = 21'h0d800;
    localparam logic [AccumW-1:0] SurrHigh     = 21'h0dfff;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [PendW-1:0]   pending_count;
        logic [AccumW-1:0]  code_accum;
        logic [SeqLenW-1:0] seq_length;
        logic               error_seen;
    } t_dec_state;

    localparam t_dec_state DecStateReset = '{
        pending_count: '0,
        code_accum:    '0,
        seq_length:    '0,
        error_seen:    1'b0
    };

endpackage

// ----- hdl/utf8_stream_validator.sv -----
// Top level of the UTF-8 stream validator: input register, decoder state,
// result register. Depends on utf8v_pkg and utf8v_step.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one byte of a string per
//   transaction in i_data_byte, with i_last_byte set on the final byte.
//   Output channel (o_valid / i_stall) carries one transaction per string,
//   o_string_valid = 1 when the whole string is well-formed UTF-8 with no
//   control characters.
//   Throughput: one byte per cycle while no final byte waits for a
//   busy result register, set by the single decode step between the
//   input register and the state/result registers.
//   Verdict path: the final byte is decoded from the input register
//   into the result register, which drives o_valid.
//   Stalls: while a verdict waits under i_stall, non-final bytes still
//   flow through; a final byte is held in the input register until the
//   result register is free, and o_stall is raised behind it.
//   Reset: i_rst_n (synchronous, active low) empties both registers and
//   returns the decoder to the start of a string.
module utf8_stream_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [utf8v_pkg::DataW-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_string_valid
);

    logic                          r_in_valid;
    logic [utf8v_pkg::DataW-1:0]   r_data_byte;
    logic                          r_last_byte;
    utf8v_pkg::t_dec_state         r_state;
    utf8v_pkg::t_dec_state         n_state;
    logic                          r_out_valid;
    logic                          r_string_valid;
    logic                          n_string_valid;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    // Decode the held byte against the current state
    utf8v_step u_step (
        .i_state        (r_state),
        .i_data_byte    (r_data_byte),
        .i_last_byte    (r_last_byte),
        .o_state        (n_state),
        .o_string_valid (n_string_valid)
    );

    // Handshake: a final byte needs a free result slot to advance
    assign out_free = ~r_out_valid | ~i_stall;
    assign advance  = r_in_valid & (~r_last_byte | out_free);
    assign o_stall  = r_in_valid & ~advance;
    assign in_take  = i_valid & ~o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    // Decoder state: advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utf8v_pkg::DecStateReset;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a final byte, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last_byte) begin
            r_string_valid <= n_string_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_string_valid = r_string_valid;

endmodule

// ----- hdl/utf8v_step.sv -----
// Per-byte UTF-8 decode step: next decoder state and string verdict.
// Purely combinational; depends on utf8v_pkg.
module utf8v_step (
    input  utf8v_pkg::t_dec_state           i_state,
    input  logic [utf8v_pkg::DataW-1:0]     i_data_byte,
    input  logic                            i_last_byte,
    output utf8v_pkg::t_dec_state           o_state,
    output logic                            o_string_valid
);

    utf8v_pkg::t_dec_state       s;
    logic [utf8v_pkg::AccumW-1:0] acc;
    logic [utf8v_pkg::AccumW-1:0] min_val;
    logic [utf8v_pkg::PendW-1:0]  pend_dec;

    // Overlong minimum for the current sequence length
    always_comb begin
        case (i_state.seq_length)
            utf8v_pkg::SeqTwoByte:   min_val = utf8v_pkg::MinTwoByte;
            utf8v_pkg::SeqThreeByte: min_val = utf8v_pkg::MinThreeByte;
            default:                 min_val = utf8v_pkg::MinFourByte;
        endcase
    end

    // Shift in six payload bits of a continuation byte
    assign acc      = {i_state.code_accum[utf8v_pkg::AccumW-7:0], i_data_byte[5:0]};
    assign pend_dec = i_state.pending_count - utf8v_pkg::PendW'(1);

    // Decode one byte as a lead or continuation byte
    always_comb begin
        s = i_state;
        if (i_state.pending_count == '0) begin
            if (i_data_byte[7] == 1'b0) begin
                if (i_data_byte < utf8v_pkg::CtrlLimit || i_data_byte == utf8v_pkg::DelChar) begin
                    s.error_seen = 1'b1;
                end
            end else if (i_data_byte inside {[8'hc2:8'hdf]}) begin
                s.pending_count = 2'd1;
                s.seq_length    = utf8v_pkg::SeqTwoByte;
                s.code_accum    = {16'd0, i_data_byte[4:0]};
            end else if (i_data_byte inside {[8'he0:8'hef]}) begin
                s.pending_count = 2'd2;
                s.seq_length    = utf8v_pkg::SeqThreeByte;
                s.code_accum    = {17'd0, i_data_byte[3:0]};
            end else if (i_data_byte inside {[8'hf0:8'hf4]}) begin
                s.pending_count = 2'd3;
                s.seq_length    = utf8v_pkg::SeqFourByte;
                s.code_accum    = {18'd0, i_data_byte[2:0]};
            end else begin
                s.error_seen = 1'b1;
            end
        end else if (i_data_byte[7:6] != 2'b10) begin
            // Bad continuation: flag and resync on lead bytes
            s.error_seen    = 1'b1;
            s.pending_count = '0;
        end else begin
            s.code_accum    = acc;
            s.pending_count = pend_dec;
            if (pend_dec == '0) begin
                if (acc < min_val || acc > utf8v_pkg::MaxCodePoint ||
                    (acc >= utf8v_pkg::SurrLow && acc <= utf8v_pkg::SurrHigh)) begin
                    s.error_seen = 1'b1;
                end
            end
        end
    end

    // Close the string on its last byte: truncation check and state clear
    always_comb begin
        o_string_valid = ~(s.error_seen | (s.pending_count != '0));
        o_state        = i_last_byte ? utf8v_pkg::DecStateReset : s;
    end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for utf8_stream_validator: directed strings, then random
// UTF-8 strings with injected faults, under random sender gaps and receiver stalls.
// Depends on utf8v_pkg and the utf8_stream_validator RTL, including utf8v_step.

// Tracks the decoder per accepted byte and holds the verdicts still due
class utf8_verdict_board;
    logic [utf8v_pkg::PendW-1:0]   due_count;
    logic [utf8v_pkg::AccumW-1:0]  point;
    logic [utf8v_pkg::SeqLenW-1:0] seq_len;
    logic                          bad;
    logic                          verdict_q[$];
    int                            errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        due_count = '0;
        point     = '0;
        seq_len   = '0;
        bad       = 1'b0;
    endfunction

    // Advance the decoder by one accepted byte; queue a verdict on the last one
    function void note_byte(input logic [utf8v_pkg::DataW-1:0] b, input logic last);
        logic [utf8v_pkg::AccumW-1:0] floor_pt;
        if (due_count == '0) begin
            if (b < 8'h80) begin
                if (b < utf8v_pkg::CtrlLimit || b == utf8v_pkg::DelChar) bad = 1'b1;
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
                due_count = 2'd1;
                seq_len   = utf8v_pkg::SeqTwoByte;
                point     = {16'b0, b[4:0]};
            end else if (b >= 8'he0 && b <= 8'hef) begin
                due_count = 2'd2;
                seq_len   = utf8v_pkg::SeqThreeByte;
                point     = {17'b0, b[3:0]};
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
                due_count = 2'd3;
                seq_len   = utf8v_pkg::SeqFourByte;
                point     = {18'b0, b[2:0]};
            end else begin
                bad = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            // broken sequence: drop it and read on as lead bytes
            bad       = 1'b1;
            due_count = '0;
        end else begin
            point     = {point[utf8v_pkg::AccumW-7:0], b[5:0]};
            due_count = due_count - 2'd1;
            if (due_count == '0) begin
                case (seq_len)
                    utf8v_pkg::SeqTwoByte:   floor_pt = utf8v_pkg::MinTwoByte;
                    utf8v_pkg::SeqThreeByte: floor_pt = utf8v_pkg::MinThreeByte;
                    default:                 floor_pt = utf8v_pkg::MinFourByte;
                endcase
                if (point < floor_pt || point > utf8v_pkg::MaxCodePoint ||
                    (point >= utf8v_pkg::SurrLow && point <= utf8v_pkg::SurrHigh))
                    bad = 1'b1;
            end
        end
        if (last) begin
            // a sequence cut short by the end of the string is invalid
            if (due_count != '0) bad = 1'b1;
            verdict_q.insert(verdict_q.size(), !bad);
            restart();
        end
    endfunction

    // Compare one received verdict with the oldest one due
    function void check_verdict(input logic got, input longint unsigned stamp);
        logic want;
        if (verdict_q.size() == 0) begin
            $display("%0d ns: string_valid %b received, expected none", stamp, got);
            errors++;
        end else begin
            want = verdict_q.pop_front();
            if (got !== want) begin
                $display("%0d ns: string_valid expected %b, got %b", stamp, want, got);
                errors++;
            end
        end
    endfunction

    function bit drained();
        return verdict_q.size() == 0;
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TargetBytes = 1850;
    localparam int unsigned NumDirected = 13;

    // Fault kinds injected into random strings
    localparam int unsigned FaultRandomByte = 0;
    localparam int unsigned FaultControl    = 1;
    localparam int unsigned FaultBrokenCont = 2;
    localparam int unsigned FaultOverlong   = 3;
    localparam int unsigned FaultSurrogate  = 4;
    localparam int unsigned FaultAboveMax   = 5;
    localparam int unsigned FaultTruncated  = 6;

    // Receiver stall modes
    localparam int unsigned StallNone  = 0;
    localparam int unsigned StallLight = 1;
    localparam int unsigned StallHeavy = 2;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic [utf8v_pkg::DataW-1:0] i_data_byte = '0;
    logic                        i_last_byte = 1'b0;
    logic                        i_stall     = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic                        o_string_valid;

    utf8_verdict_board board;
    logic [7:0]        str_bytes[$];
    logic [7:0]        seq_bytes[$];
    int unsigned       bytes_sent = 0;
    int unsigned       burst_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_mode = StallNone;

    // Length in the top byte, string bytes first-to-last below it
    logic [39:0] directed_set [NumDirected] = '{
        {8'd1, 32'h41000000},   // plain printable
        {8'd1, 32'h00000000},   // lowest control character
        {8'd1, 32'h7f000000},   // delete
        {8'd1, 32'h1f000000},   // highest low control character
        {8'd2, 32'hc2800000},   // smallest two-byte form
        {8'd1, 32'hc1000000},   // bad lead byte
        {8'd3, 32'he09fbf00},   // overlong three-byte form
        {8'd3, 32'heda08000},   // surrogate
        {8'd4, 32'hf48fbfbf},   // highest code point
        {8'd4, 32'hf4908080},   // above the highest code point
        {8'd1, 32'hff000000},   // highest byte, bad lead
        {8'd2, 32'hc3410000},   // bad continuation byte
        {8'd2, 32'he2820000}    // sequence cut short at the end
    };

    utf8_stream_validator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_string_valid (o_string_valid)
    );

    always #10 i_clk = ~i_clk;

    // Receiver stall pattern: switch mode every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(StallNone, StallHeavy);
            stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (stall_mode)
            StallNone:  i_stall <= 1'b0;
            StallLight: i_stall <= ($urandom_range(0, 3) == 0);
            default:    i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sample both channels; check results before noting new bytes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0)
                board.check_verdict(o_string_valid, $time);
            if (i_valid && o_stall === 1'b0)
                board.note_byte(i_data_byte, i_last_byte);
        end
    end

    // Encode a code point in the given number of bytes (overlong forms allowed)
    function automatic void encode_point(input logic [20:0] cp, input int unsigned len);
        seq_bytes.delete();
        case (len)
            1: seq_bytes.insert(seq_bytes.size(), {1'b0, cp[6:0]});
            2: begin
                seq_bytes.insert(seq_bytes.size(), {3'b110, cp[10:6]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
            end
            3: begin
                seq_bytes.insert(seq_bytes.size(), {4'b1110, cp[15:12]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
            end
            default: begin
                seq_bytes.insert(seq_bytes.size(), {5'b11110, cp[20:18]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[17:12]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[11:6]});
                seq_bytes.insert(seq_bytes.size(), {2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Pick a well-formed code point of the given length, ends of the range now and then
    function automatic logic [20:0] pick_point(input int unsigned len);
        int unsigned lo, hi, v;
        case (len)
            1:       begin lo = 'h20;    hi = 'h7e;     end
            2:       begin lo = 'h80;    hi = 'h7ff;    end
            3:       begin lo = 'h800;   hi = 'hffff;   end
            default: begin lo = 'h10000; hi = 'h10ffff; end
        endcase
        case ($urandom_range(0, 15))
            0:       v = lo;
            1:       v = hi;
            default: v = $urandom_range(lo, hi);
        endcase
        // move surrogates out of the way
        if (v >= 'hd800 && v <= 'hdfff) v = v ^ 'h2000;
        return v[20:0];
    endfunction

    // Build a random string: mostly well-formed, some sequences spoilt
    task automatic build_random_string();
        int unsigned n, len, pos;
        logic [7:0]  b;
        str_bytes.delete();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        repeat (n) begin
            len = $urandom_range(1, 4);
            if ($urandom_range(0, 99) < 85) begin
                encode_point(pick_point(len), len);
            end else begin
                len = $urandom_range(2, 4);
                case ($urandom_range(FaultRandomByte, FaultTruncated))
                    FaultRandomByte: begin
                        seq_bytes.delete();
                        seq_bytes.insert(0, 8'($urandom_range(0, 255)));
                    end
                    FaultControl: begin
                        seq_bytes.delete();
                        seq_bytes.insert(0, ($urandom_range(0, 1) == 0) ?
                                         8'($urandom_range(0, 31)) : utf8v_pkg::DelChar);
                    end
                    FaultBrokenCont: begin
                        encode_point(pick_point(len), len);
                        pos = $urandom_range(1, len - 1);
                        b = 8'($urandom_range(0, 255));
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        seq_bytes[pos] = b;
                    end
                    FaultOverlong: begin
                        encode_point(21'($urandom_range(0, (len == 2) ? 'h7f :
                                                        (len == 3) ? 'h7ff : 'hffff)), len);
                    end
                    FaultSurrogate: encode_point(21'($urandom_range('hd800, 'hdfff)), 3);
                    FaultAboveMax:  encode_point(21'($urandom_range('h110000, 'h1fffff)), 4);
                    default: begin
                        encode_point(pick_point(len), len);
                        repeat ($urandom_range(1, len - 1)) void'(seq_bytes.pop_back());
                    end
                endcase
            end
            foreach (seq_bytes[k]) str_bytes.insert(str_bytes.size(), seq_bytes[k]);
        end
    endtask

    // Offer one byte, with a random gap at the start of each burst; hold until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        bytes_sent++;
    endtask

    task automatic send_string();
        foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
    endtask

    // Hold the sender off until every verdict due has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (!board.drained()) @(posedge i_clk);
    endtask

    initial begin
        int unsigned n;
        board = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings
        for (int d = 0; d < NumDirected; d++) begin
            str_bytes.delete();
            n = {24'd0, directed_set[d][39:32]};
            for (int k = 0; k < n; k++)
                str_bytes.insert(str_bytes.size(), directed_set[d][31 - 8*k -: 8]);
            send_string();
        end
        drain_results();

        // Random strings
        while (bytes_sent < TargetBytes) begin
            build_random_string();
            send_string();
            if ($urandom_range(0, 39) == 0) drain_results();
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        if (board.errors == 0 && board.drained()) begin
            $display("end of test: clean");
        end else begin
            if (!board.drained())
                $display("%0d ns: %0d verdicts never arrived", $time, board.verdict_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
